@@ src/s128e_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// s128e_pkg
// Shared constants, types and round functions of the SIMON128/256 encryptor.
// ---------------------------------------------------------------------------
package s128e_pkg;

    localparam int ROUND_COUNT = 72;
    localparam int RK_IDX_W    = $clog2(ROUND_COUNT);
    localparam int WORD_W      = 64;
    localparam int CFG_INDEX_W = 8;
    localparam int KEY_WORDS   = 4;

    localparam logic [WORD_W-1:0]   Z_SEQ       = 64'h3dc94c3a046d678b;
    localparam logic [WORD_W-1:0]   C_CONST     = 64'hfffffffffffffffc;
    localparam logic [RK_IDX_W-1:0] Z_LEN       = RK_IDX_W'(62);
    localparam logic [4:0]          BLOCK_BYTES = 5'd16;
    localparam logic [WORD_W-1:0]   PAD_WORD    = 64'h1010101010101010;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_WORD_0 = 8'd0,
        REG_KEY_WORD_1 = 8'd1,
        REG_KEY_WORD_2 = 8'd2,
        REG_KEY_WORD_3 = 8'd3
    } cfg_reg_t;

    // one pipeline slot: valid flag, left word, right word and the last flag
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] l;
        logic [WORD_W-1:0] r;
        logic              last;
    } s128e_stage_t;

    function automatic logic [WORD_W-1:0] rol64(input logic [WORD_W-1:0] x,
                                                input int unsigned n);
        rol64 = (x << n) | (x >> (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] ror64(input logic [WORD_W-1:0] x,
                                                input int unsigned n);
        ror64 = (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] simon_f(input logic [WORD_W-1:0] x);
        simon_f = (rol64(x, 1) & rol64(x, 8)) ^ rol64(x, 2);
    endfunction

    // bit of the z sequence for schedule step i, period 62
    function automatic logic z_bit(input logic [RK_IDX_W-1:0] i);
        logic [RK_IDX_W-1:0] j;
        j = (i >= Z_LEN) ? (i - Z_LEN) : i;
        z_bit = Z_SEQ[j[5:0]];
    endfunction

    function automatic logic [WORD_W-1:0] key_step(input logic [WORD_W-1:0] w0,
                                                   input logic [WORD_W-1:0] w1,
                                                   input logic [WORD_W-1:0] w3,
                                                   input logic              zb);
        logic [WORD_W-1:0] t;
        t = w1 ^ ror64(w3, 3);
        key_step = w0 ^ (C_CONST | {{(WORD_W-1){1'b0}}, zb}) ^ t ^ ror64(t, 1);
    endfunction

endpackage

@@ src/s128e_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// s128e_blk_if / s128e_ct_if
// Request channels for plaintext blocks and ciphertext blocks.
// ---------------------------------------------------------------------------
interface s128e_blk_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_low;
    logic [63:0] block_high;
    logic [4:0]  valid_bytes;
    logic        last_block;

    modport source (output valid, block_low, block_high, valid_bytes, last_block,
                    input ready);
    modport sink (input valid, block_low, block_high, valid_bytes, last_block,
                  output ready);
endinterface

interface s128e_ct_if;
    logic        valid;
    logic        ready;
    logic [63:0] cipher_low;
    logic [63:0] cipher_high;
    logic        last_out;

    modport source (output valid, cipher_low, cipher_high, last_out, input ready);
    modport sink (input valid, cipher_low, cipher_high, last_out, output ready);
endinterface

@@ src/simon128_256_pkcs7_encryptor.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// simon128_256_pkcs7_encryptor
// SIMON128/256 ECB encryptor with PKCS#7 padding of the final block.
//
// channel  kind     direction  payload
// plain    request  in         block_low, block_high, valid_bytes, last_block
// cipher   request  out        cipher_low, cipher_high, last_out
// cfg      write    in         cfg_we, cfg_index, cfg_data (key words 0..3)
//
// one block per cycle unless stalled; a full final block adds a pad block
// pipeline: pad stage, one register per round (72), output buffer
// after reset and after every key write the round key expander runs
// (one load step, then one key per cycle), plain.ready stays low meanwhile
// a stalled cipher channel freezes the whole pipeline once the two-entry
// output buffer is full; nothing is lost or repeated
// ---------------------------------------------------------------------------
module simon128_256_pkcs7_encryptor import s128e_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_data,
    s128e_blk_if.sink              plain,
    s128e_ct_if.source             cipher
);

    logic [ROUND_COUNT-1:0][WORD_W-1:0] rk_bus;
    logic                               key_ready;
    logic                               en;
    s128e_stage_t                       stage [ROUND_COUNT+1];

    s128e_keysched u_keysched (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .rk_bus     (rk_bus),
        .key_ready  (key_ready)
    );

    s128e_pad u_pad (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .key_ready (key_ready),
        .plain     (plain),
        .q         (stage[0])
    );

    for (genvar i = 0; i < ROUND_COUNT; i++)
    begin : g_round
        s128e_round u_round (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .key   (rk_bus[i]),
            .d     (stage[i]),
            .q     (stage[i+1])
        );
    end

    s128e_skid u_skid (
        .clk    (clk),
        .rst_n  (rst_n),
        .d      (stage[ROUND_COUNT]),
        .en     (en),
        .cipher (cipher)
    );

endmodule

@@ src/s128e_keysched.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// s128e_keysched
// Key registers and an iterative round key expander, one key per cycle.
// ---------------------------------------------------------------------------
module s128e_keysched import s128e_pkg::*;
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [CFG_INDEX_W-1:0]              cfg_index,
    input  logic [WORD_W-1:0]                   cfg_data,
    output logic [ROUND_COUNT-1:0][WORD_W-1:0]  rk_bus,
    output logic                                key_ready
);

    logic [WORD_W-1:0]   key_reg  [KEY_WORDS];
    logic [WORD_W-1:0]   key_next [KEY_WORDS];
    logic [WORD_W-1:0]   w_reg    [KEY_WORDS];
    logic [WORD_W-1:0]   w_next   [KEY_WORDS];
    logic [WORD_W-1:0]   rk_reg   [ROUND_COUNT];
    logic                pending_reg, pending_next;
    logic                busy_reg, busy_next;
    logic [RK_IDX_W-1:0] cnt_reg, cnt_next;
    logic                rk_we;

    always_comb
    begin
        for (int i = 0; i < KEY_WORDS; i++)
        begin
            key_next[i] = key_reg[i];
        end
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_WORD_0: key_next[0] = cfg_data;
                REG_KEY_WORD_1: key_next[1] = cfg_data;
                REG_KEY_WORD_2: key_next[2] = cfg_data;
                REG_KEY_WORD_3: key_next[3] = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        pending_next = cfg_we;
        busy_next    = busy_reg;
        cnt_next     = cnt_reg;
        rk_we        = 1'b0;
        for (int i = 0; i < KEY_WORDS; i++)
        begin
            w_next[i] = w_reg[i];
        end
        if (pending_reg)
        begin
            // restart the pass from the stored key
            busy_next = 1'b1;
            cnt_next  = '0;
            for (int i = 0; i < KEY_WORDS; i++)
            begin
                w_next[i] = key_reg[i];
            end
        end
        else if (busy_reg)
        begin
            rk_we     = 1'b1;
            busy_next = (cnt_reg != RK_IDX_W'(ROUND_COUNT - 1));
            cnt_next  = cnt_reg + RK_IDX_W'(1);
            w_next[0] = w_reg[1];
            w_next[1] = w_reg[2];
            w_next[2] = w_reg[3];
            w_next[3] = key_step(w_reg[0], w_reg[1], w_reg[3], z_bit(cnt_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_WORDS; i++)
            begin
                key_reg[i] <= '0;
            end
            pending_reg <= 1'b1;
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            for (int i = 0; i < KEY_WORDS; i++)
            begin
                key_reg[i] <= key_next[i];
            end
            pending_reg <= pending_next;
            busy_reg    <= busy_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < KEY_WORDS; i++)
        begin
            w_reg[i] <= w_next[i];
        end
        if (rk_we)
        begin
            rk_reg[cnt_reg] <= w_reg[0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < ROUND_COUNT; i++)
        begin
            rk_bus[i] = rk_reg[i];
        end
    end

    assign key_ready = !pending_reg && !busy_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg < RK_IDX_W'(ROUND_COUNT)))
        else $error("key schedule counter out of range");

    a_write_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !key_ready)
        else $error("key write did not hold off blocks");

endmodule

@@ src/s128e_pad.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// s128e_pad
// Entry stage: PKCS#7 padding of the final block and the extra pad block.
// ---------------------------------------------------------------------------
module s128e_pad import s128e_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          key_ready,
    s128e_blk_if.sink     plain,
    output s128e_stage_t  q
);

    logic              valid_reg, valid_next;
    logic              extra_reg, extra_next;
    logic [WORD_W-1:0] l_reg, r_reg, l_next, r_next;
    logic              last_reg, last_next;
    logic              take;
    logic [4:0]        vc;
    logic [7:0]        pad_byte;
    logic [127:0]      blk;
    logic              is_full;

    assign plain.ready = en && !extra_reg && key_ready;
    assign take        = plain.ready && plain.valid;

    always_comb
    begin
        vc       = (plain.valid_bytes > BLOCK_BYTES) ? BLOCK_BYTES : plain.valid_bytes;
        pad_byte = {3'b000, 5'(BLOCK_BYTES - vc)};
        blk      = {plain.block_high, plain.block_low};
        for (int j = 0; j < 16; j++)
        begin
            if (plain.last_block && (5'(j) >= vc))
            begin
                blk[j*8 +: 8] = pad_byte;
            end
        end
        is_full = plain.last_block && (vc == BLOCK_BYTES);

        valid_next = valid_reg;
        extra_next = extra_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        last_next  = last_reg;
        if (en)
        begin
            valid_next = extra_reg || take;
            extra_next = !extra_reg && take && is_full;
            if (extra_reg)
            begin
                // block made only of padding after a full final block
                l_next    = PAD_WORD;
                r_next    = PAD_WORD;
                last_next = 1'b1;
            end
            else
            begin
                l_next    = blk[63:0];
                r_next    = blk[127:64];
                last_next = plain.last_block && !is_full;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            extra_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            extra_reg <= extra_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg    <= l_next;
        r_reg    <= r_next;
        last_reg <= last_next;
    end

    assign q.valid = valid_reg;
    assign q.l     = l_reg;
    assign q.r     = r_reg;
    assign q.last  = last_reg;

    a_extra_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        extra_reg |-> !plain.ready)
        else $error("request taken while pad block pending");

    a_extra_emitted: assert property (@(posedge clk) disable iff (!rst_n)
        (extra_reg && en) |=> (valid_reg && last_reg && !extra_reg))
        else $error("pad block not issued as final block");

endmodule

@@ src/s128e_round.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// s128e_round
// One SIMON round with its pipeline register.
// ---------------------------------------------------------------------------
module s128e_round import s128e_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [WORD_W-1:0] key,
    input  s128e_stage_t      d,
    output s128e_stage_t      q
);

    logic              valid_reg;
    logic [WORD_W-1:0] l_reg, r_reg;
    logic              last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= d.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_reg    <= d.r;
            r_reg    <= d.l ^ simon_f(d.r) ^ key;
            last_reg <= d.last;
        end
    end

    assign q.valid = valid_reg;
    assign q.l     = l_reg;
    assign q.r     = r_reg;
    assign q.last  = last_reg;

endmodule

@@ src/s128e_skid.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// s128e_skid
// Two-entry output buffer; its fill level drives the pipeline advance.
// ---------------------------------------------------------------------------
module s128e_skid import s128e_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  s128e_stage_t  d,
    output logic          en,
    s128e_ct_if.source    cipher
);

    s128e_stage_t ent_reg [2];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   count_reg, count_next;
    logic         push, pop;

    assign en   = (count_reg != 2'd2);
    assign push = en && d.valid;
    assign pop  = cipher.valid && cipher.ready;

    assign count_next = count_reg + 2'(push) - 2'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= d;
        end
    end

    assign cipher.valid       = (count_reg != 2'd0);
    assign cipher.cipher_low  = ent_reg[rd_ptr_reg].l;
    assign cipher.cipher_high = ent_reg[rd_ptr_reg].r;
    assign cipher.last_out    = ent_reg[rd_ptr_reg].last;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("output buffer overfilled");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 2'd1))
        else $error("output buffer level wrong after pop");

endmodule
